FILE: rtl/core/sfd_pkg.sv
// Shared types, register codes and arithmetic helpers for the stereo feedback delay.
package sfd_pkg;

  // Sample format and ring geometry (ring depth is a power of two)
  localparam int SAMPLE_BITS = 24;
  localparam int RING_AW     = 15;
  localparam int RING_DEPTH  = 1 << RING_AW;

  // Coefficient and control widths
  localparam int COEF_W  = 16;
  localparam int LAG_W   = 15;
  localparam int PITCH_W = 15;
  localparam int GAIN_W  = 25;
  localparam int FRAC15  = 15;
  localparam int FRAC14  = 14;
  localparam int DROP_SH = 9;

  // Queue between front and back
  localparam int QUEUE_AW    = 2;
  localparam int QUEUE_DEPTH = 1 << QUEUE_AW;

  // Configuration port
  localparam int CFG_AW = 3;
  localparam int CFG_DW = 16;
  localparam logic [CFG_AW-1:0] REG_FEEDBACK_GAIN = 3'd0;
  localparam logic [CFG_AW-1:0] REG_ECHO_MIX      = 3'd1;
  localparam logic [CFG_AW-1:0] REG_VOLUME        = 3'd2;
  localparam logic [CFG_AW-1:0] REG_GAIN_BASE     = 3'd3;
  localparam logic [CFG_AW-1:0] REG_PITCH_SLOPE   = 3'd4;
  localparam logic [CFG_AW-1:0] REG_LEFT_TAP_LAG  = 3'd5;
  localparam logic [CFG_AW-1:0] REG_RIGHT_TAP_LAG = 3'd6;

  // Saturation input width
  localparam int SAT_W = 64;
  localparam logic signed [SAT_W-1:0] SAT_HI = (64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1;
  localparam logic signed [SAT_W-1:0] SAT_LO = -SAT_HI - 64'sd1;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic signed [GAIN_W-1:0]      gain_t;
  typedef logic        [COEF_W-1:0]      coef_t;
  typedef logic        [LAG_W-1:0]       lag_t;
  typedef logic        [PITCH_W-1:0]     pitch_t;
  typedef logic        [RING_AW-1:0]     ring_addr_t;

  typedef struct packed {
    coef_t feedback_gain;
    coef_t echo_mix;
    coef_t volume;
    coef_t gain_base;
    coef_t pitch_slope;
    lag_t  left_tap_lag;
    lag_t  right_tap_lag;
  } cfg_t;

  typedef struct packed {
    sample_t dry;
    gain_t   gain;
  } mid_item_t;

  // Clamp a wide signed value to the sample range
  function automatic sample_t sat_sample(logic signed [SAT_W-1:0] v);
    sample_t r;
    if (v > SAT_HI) begin
      r = SAT_HI[SAMPLE_BITS-1:0];
    end else if (v < SAT_LO) begin
      r = SAT_LO[SAMPLE_BITS-1:0];
    end else begin
      r = v[SAMPLE_BITS-1:0];
    end
    return r;
  endfunction

  // Reduce a lag modulo the ring depth
  function automatic ring_addr_t lag_to_offset(lag_t lag);
    logic [RING_AW+LAG_W-1:0] wide;
    wide = {{RING_AW{1'b0}}, lag};
    return wide[RING_AW-1:0];
  endfunction

endpackage

FILE: rtl/core/sfd_front.sv
// Front pipeline: accepts samples and computes the pitch dependent output gain.
module sfd_front (
  input  logic              clk,
  input  logic              rst,
  input  sfd_pkg::cfg_t     cfg,
  input  logic              push,
  output logic              full,
  input  sfd_pkg::sample_t  dry_sample,
  input  sfd_pkg::pitch_t   pitch,
  output logic              q_push,
  input  logic              q_full,
  output sfd_pkg::mid_item_t q_item
);
  import sfd_pkg::*;

  localparam int SP_W   = PITCH_W + COEF_W;
  localparam int DROP_W = SP_W - DROP_SH;
  localparam int G14_W  = DROP_W + 1;
  localparam int GP_W   = G14_W + COEF_W + 1;

  logic                    a_valid;
  sample_t                 a_dry;
  logic [SP_W-1:0]         a_prod;
  logic                    b_valid;
  sample_t                 b_dry;
  logic signed [GP_W-1:0]  b_prod;

  logic                    a_ready;
  logic                    b_ready;
  logic [DROP_W-1:0]       drop;
  logic signed [G14_W-1:0] g14;

  // Stage handshakes
  assign b_ready = !b_valid || !q_full;
  assign a_ready = !a_valid || b_ready;
  assign full    = !a_ready;

  // Gain before the volume multiply
  assign drop = a_prod[SP_W-1:DROP_SH];
  assign g14  = $signed(G14_W'(cfg.gain_base)) - $signed({1'b0, drop});

  // Stage A: pitch times slope
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (a_ready) begin
      a_valid <= push;
    end
    if (a_ready) begin
      a_dry  <= dry_sample;
      a_prod <= SP_W'(pitch) * SP_W'(cfg.pitch_slope);
    end
  end

  // Stage B: scale by volume
  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (b_ready) begin
      b_valid <= a_valid;
    end
    if (b_ready) begin
      b_dry  <= a_dry;
      b_prod <= g14 * $signed({1'b0, cfg.volume});
    end
  end

  // Hand the item to the queue
  assign q_push      = b_valid && !q_full;
  assign q_item.dry  = b_dry;
  assign q_item.gain = b_prod[GP_W-1:FRAC15];

endmodule

FILE: rtl/core/sfd_queue.sv
// Short first-word-fall-through queue between the front and the back.
module sfd_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  sfd_pkg::mid_item_t push_item,
  output logic               full,
  input  logic               pop,
  output sfd_pkg::mid_item_t head,
  output logic               empty
);
  import sfd_pkg::*;

  mid_item_t           entries [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr;
  logic [QUEUE_AW-1:0] rd_ptr;
  logic [QUEUE_AW:0]   count;

  assign full  = count == (QUEUE_AW + 1)'(QUEUE_DEPTH);
  assign empty = count == '0;
  assign head  = entries[rd_ptr];

  // Store pushed items
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

FILE: rtl/core/sfd_back.sv
// Back sequencer: ring read, feedback write, tap mix and output register per sample.
module sfd_back (
  input  logic               clk,
  input  logic               rst,
  input  sfd_pkg::cfg_t      cfg,
  input  logic               item_valid,
  input  sfd_pkg::mid_item_t item,
  output logic               item_take,
  output logic               res_valid,
  input  logic               res_take,
  output sfd_pkg::sample_t   left_res,
  output sfd_pkg::sample_t   right_res
);
  import sfd_pkg::*;

  localparam int LANES  = 2;
  localparam int FBP_W  = COEF_W + 1 + SAMPLE_BITS;
  localparam int FB_W   = FBP_W - FRAC15;
  localparam int SUM1_W = FB_W + 1;
  localparam int MIXP_W = SUM1_W + COEF_W + 1;
  localparam int MIX_W  = MIXP_W - FRAC15;
  localparam int SUM2_W = SAMPLE_BITS + 1;
  localparam int OUTP_W = SUM2_W + GAIN_W;
  localparam int OUT_W  = OUTP_W - FRAC14;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_FB    = 3'd1;
  localparam logic [2:0] ST_MIX   = 3'd2;
  localparam logic [2:0] ST_WRITE = 3'd3;
  localparam logic [2:0] ST_OUT   = 3'd4;
  localparam logic [2:0] ST_DONE  = 3'd5;

  sample_t left_ring  [RING_DEPTH];
  sample_t right_ring [RING_DEPTH];

  logic [2:0]                state;
  ring_addr_t                write_index;
  logic                      wrapped;
  sample_t                   dry_q;
  gain_t                     gain_q;
  logic                      tap_ok_q   [LANES];
  logic                      zero_lag_q [LANES];
  sample_t                   left_rd;
  sample_t                   right_rd;
  sample_t                   tap_q      [LANES];
  logic signed [FBP_W-1:0]   fb_prod_q  [LANES];
  logic signed [MIXP_W-1:0]  mix_prod_q [LANES];
  logic signed [SUM2_W-1:0]  sum2_q     [LANES];
  logic signed [OUTP_W-1:0]  out_prod_q [LANES];
  sample_t                   res_q      [LANES];

  ring_addr_t                tap_addr   [LANES];
  ring_addr_t                lag_off    [LANES];
  sample_t                   tap_raw    [LANES];
  sample_t                   tap_cur    [LANES];
  logic signed [FB_W-1:0]    fb         [LANES];
  logic signed [SUM1_W-1:0]  sum1       [LANES];
  logic signed [MIX_W-1:0]   mix_sh     [LANES];
  sample_t                   entry      [LANES];
  sample_t                   tap_new    [LANES];
  logic signed [OUT_W-1:0]   out_sh     [LANES];
  sample_t                   out_sat    [LANES];
  logic                      res_push;

  assign item_take = (state == ST_IDLE) && item_valid;
  assign res_push  = (state == ST_DONE) && (!res_valid || res_take);
  assign left_res  = res_q[0];
  assign right_res = res_q[1];

  // Per-lane datapath
  always_comb begin
    lag_off[0] = lag_to_offset(cfg.left_tap_lag);
    lag_off[1] = lag_to_offset(cfg.right_tap_lag);
    tap_raw[0] = left_rd;
    tap_raw[1] = right_rd;
    for (int l = 0; l < LANES; l++) begin
      tap_addr[l] = write_index - lag_off[l];
      // Entries not yet written since reset read as zero
      tap_cur[l]  = tap_ok_q[l] ? tap_raw[l] : '0;
      fb[l]       = fb_prod_q[l][FBP_W-1:FRAC15];
      sum1[l]     = SUM1_W'(dry_q) + SUM1_W'(fb[l]);
      mix_sh[l]   = mix_prod_q[l][MIXP_W-1:FRAC15];
      entry[l]    = sat_sample(SAT_W'(mix_sh[l]));
      // A zero lag sees the entry just written
      tap_new[l]  = zero_lag_q[l] ? entry[l] : tap_q[l];
      out_sh[l]   = out_prod_q[l][OUTP_W-1:FRAC14];
      out_sat[l]  = sat_sample(SAT_W'(out_sh[l]));
    end
  end

  // Left ring: read the tap on start, write the new entry
  always_ff @(posedge clk) begin
    if (item_take) begin
      left_rd <= left_ring[tap_addr[0]];
    end
    if (state == ST_WRITE) begin
      left_ring[write_index] <= entry[0];
    end
  end

  // Right ring: read the tap on start, write the new entry
  always_ff @(posedge clk) begin
    if (item_take) begin
      right_rd <= right_ring[tap_addr[1]];
    end
    if (state == ST_WRITE) begin
      right_ring[write_index] <= entry[1];
    end
  end

  // Sequencer control
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      write_index <= '0;
      wrapped     <= 1'b0;
      res_valid   <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (item_valid) begin
            state <= ST_FB;
          end
        end
        ST_FB:    state <= ST_MIX;
        ST_MIX:   state <= ST_WRITE;
        ST_WRITE: state <= ST_OUT;
        ST_OUT:   state <= ST_DONE;
        ST_DONE: begin
          if (res_push) begin
            state       <= ST_IDLE;
            write_index <= write_index + 1'b1;
            if (&write_index) begin
              wrapped <= 1'b1;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
      if (res_push) begin
        res_valid <= 1'b1;
      end else if (res_take) begin
        res_valid <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (item_take) begin
      dry_q  <= item.dry;
      gain_q <= item.gain;
      for (int l = 0; l < LANES; l++) begin
        tap_ok_q[l]   <= wrapped || (tap_addr[l] < write_index);
        zero_lag_q[l] <= lag_off[l] == '0;
      end
    end
    for (int l = 0; l < LANES; l++) begin
      if (state == ST_FB) begin
        tap_q[l]     <= tap_cur[l];
        fb_prod_q[l] <= $signed({1'b0, cfg.feedback_gain}) * tap_cur[l];
      end
      if (state == ST_MIX) begin
        mix_prod_q[l] <= sum1[l] * $signed({1'b0, cfg.echo_mix});
      end
      if (state == ST_WRITE) begin
        sum2_q[l] <= SUM2_W'(dry_q) + SUM2_W'(tap_new[l]);
      end
      if (state == ST_OUT) begin
        out_prod_q[l] <= sum2_q[l] * gain_q;
      end
      if (res_push) begin
        res_q[l] <= out_sat[l];
      end
    end
  end

endmodule

FILE: rtl/core/stereo_feedback_delay.sv
// Stereo feedback delay top level: configuration registers, front, queue and back.
//
// Input channel: drive dry_sample and pitch with push; a transaction completes on a
// clock edge where push is high and full is low. Result channel: left_out and
// right_out hold the oldest result while empty is low; pop on such an edge takes it.
// Configuration: cfg_write with cfg_index and cfg_data writes one register;
// index 0 feedback_gain, 1 echo_mix, 2 volume, 3 gain_base, 4 pitch_slope,
// 5 left_tap_lag, 6 right_tap_lag; other indexes are ignored. Write only while idle.
// The back sequencer takes one sample at a time and accepts the next only after
// it has handed over the result; per sample it reads both rings, runs three
// dependent multiplies per lane and writes the rings.
// The front gain pipeline and a four entry queue keep accepting samples while a
// result waits, so full rises only once the queue and front stages are occupied.
// When the receiver stalls, the finished result holds on the ports and the back
// waits before its next result. Reset clears control state, returns registers to
// their defaults and empties the rings logically through a fill mark: entries not
// written since reset read as zero, with no clearing pass.
module stereo_feedback_delay (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         push,
  output logic                         full,
  input  sfd_pkg::sample_t             dry_sample,
  input  sfd_pkg::pitch_t              pitch,
  output logic                         empty,
  input  logic                         pop,
  output sfd_pkg::sample_t             left_out,
  output sfd_pkg::sample_t             right_out,
  input  logic                         cfg_write,
  input  logic [sfd_pkg::CFG_AW-1:0]   cfg_index,
  input  logic [sfd_pkg::CFG_DW-1:0]   cfg_data
);
  import sfd_pkg::*;

  cfg_t      cfg;
  logic      q_push;
  logic      q_full;
  logic      q_pop;
  logic      q_empty;
  mid_item_t q_in;
  mid_item_t q_head;
  logic      res_valid;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.feedback_gain <= 16'd16384;
      cfg.echo_mix      <= 16'd16384;
      cfg.volume        <= 16'd32768;
      cfg.gain_base     <= 16'd16384;
      cfg.pitch_slope   <= 16'd0;
      cfg.left_tap_lag  <= 15'd12000;
      cfg.right_tap_lag <= 15'd16000;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_FEEDBACK_GAIN: cfg.feedback_gain <= cfg_data;
        REG_ECHO_MIX:      cfg.echo_mix      <= cfg_data;
        REG_VOLUME:        cfg.volume        <= cfg_data;
        REG_GAIN_BASE:     cfg.gain_base     <= cfg_data;
        REG_PITCH_SLOPE:   cfg.pitch_slope   <= cfg_data;
        REG_LEFT_TAP_LAG:  cfg.left_tap_lag  <= cfg_data[LAG_W-1:0];
        REG_RIGHT_TAP_LAG: cfg.right_tap_lag <= cfg_data[LAG_W-1:0];
        default: ;
      endcase
    end
  end

  sfd_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .push       (push),
    .full       (full),
    .dry_sample (dry_sample),
    .pitch      (pitch),
    .q_push     (q_push),
    .q_full     (q_full),
    .q_item     (q_in)
  );

  sfd_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_item (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .head      (q_head),
    .empty     (q_empty)
  );

  sfd_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .item_valid (!q_empty),
    .item       (q_head),
    .item_take  (q_pop),
    .res_valid  (res_valid),
    .res_take   (pop),
    .left_res   (left_out),
    .right_res  (right_out)
  );

  assign empty = !res_valid;

`ifndef ASSERT_OFF
  // The front never pushes into a full queue
  a_no_overflow: assert property (@(posedge clk) disable iff (rst) q_push |-> !q_full)
    else $error("front pushed into a full queue");

  // The back never pops an empty queue
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) q_pop |-> !q_empty)
    else $error("back popped an empty queue");

  // The back takes one sample at a time
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst) q_pop |=> !q_pop)
    else $error("back took two samples in consecutive cycles");
`endif

endmodule
